// ===== rtl/btc_pkg.sv =====
// Shared types, constants and helpers for the block transposition cipher.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package btc_pkg;

   localparam int MAX_BLOCK   = 8;
   localparam int TAB_ENTRIES = 8;
   localparam int LEN_CAP     = (MAX_BLOCK < TAB_ENTRIES) ? MAX_BLOCK : TAB_ENTRIES;
   localparam int IDX_W       = $clog2(MAX_BLOCK);
   localparam int ENT_W       = 3;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 4;
   localparam int TAB_W       = TAB_ENTRIES * ENT_W;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_W-1:0] BLOCK_LEN_RESET  = 4'd6;
   localparam logic [TAB_W-1:0] PERM_TABLE_RESET = 24'd16434824;
   localparam logic             DIRECTION_RESET  = 1'b0;

   typedef enum logic [1:0] {
      CSR_BLOCK_LEN  = 2'd0,
      CSR_PERM_TABLE = 2'd1,
      CSR_DIRECTION  = 2'd2
   } csr_index_type;

   typedef logic [BYTE_W-1:0] data_byte_type;

   // Settings the front end needs when a block completes.
   typedef struct packed {
      logic [IDX_W-1:0] last_idx;
      logic [TAB_W-1:0] table_bits;
      logic             decrypt;
      logic             len_write;
   } cfg_type;

   // One finished, already permuted block waiting to be sent out.
   typedef struct packed {
      data_byte_type [MAX_BLOCK-1:0] bytes;
      logic [IDX_W-1:0]              last_idx;
   } block_type;

   // Index of the last byte of a block, with the length saturated into range.
   function automatic logic [IDX_W-1:0] eff_last(input logic [LEN_W-1:0] len);
      logic [IDX_W-1:0] r;
      if (len == '0) begin
         r = '0;
      end else if (len > LEN_W'(LEN_CAP)) begin
         r = IDX_W'(LEN_CAP - 1);
      end else begin
         r = IDX_W'(len - 1'b1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/btc_front.sv =====
// Front end: collects input bytes into a block and permutes a full block.
// Depends on btc_pkg; feeds btc_queue.
`timescale 1ns / 1ps
`default_nettype none

module btc_front import btc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire data_byte_type in_byte,
   input  wire logic          q_full,
   output logic               push_valid,
   output block_type          push_block
);

   data_byte_type [MAX_BLOCK-1:0] buf_ff;
   logic [IDX_W-1:0]              fill_ff, fill_in;
   data_byte_type [MAX_BLOCK-1:0] cur;
   data_byte_type [MAX_BLOCK-1:0] res;
   logic [ENT_W-1:0]              ent;
   logic                          accept;
   logic                          block_done;

   assign in_ready   = !q_full;
   assign accept     = in_valid && in_ready;
   assign block_done = (fill_ff == cfg.last_idx);
   assign push_valid = accept && block_done;

   // The block as it stands once the incoming byte is in place.
   always_comb begin
      for (int k = 0; k < MAX_BLOCK; k++) begin
         cur[k] = (fill_ff == IDX_W'(k)) ? in_byte : buf_ff[k];
      end
   end

   // Encrypt places byte i at slot table[i], later bytes winning a collision.
   // Decrypt gathers slot j from byte table[j], or zero if out of range.
   always_comb begin
      ent = '0;
      for (int j = 0; j < MAX_BLOCK; j++) begin
         res[j] = '0;
         if (cfg.decrypt) begin
            if (j < LEN_CAP) begin
               ent = cfg.table_bits[ENT_W*j +: ENT_W];
               if (IDX_W'(ent) <= cfg.last_idx) begin
                  res[j] = cur[IDX_W'(ent)];
               end
            end
         end else begin
            for (int i = 0; i < LEN_CAP; i++) begin
               if (IDX_W'(i) <= cfg.last_idx &&
                   cfg.table_bits[ENT_W*i +: ENT_W] == ENT_W'(j)) begin
                  res[j] = cur[i];
               end
            end
         end
      end
   end

   assign push_block.bytes    = res;
   assign push_block.last_idx = cfg.last_idx;

   always_comb begin
      fill_in = fill_ff;
      if (cfg.len_write) begin
         fill_in = '0;
      end else if (accept) begin
         fill_in = block_done ? '0 : fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff[fill_ff] <= in_byte;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/btc_queue.sv =====
// Two-entry queue of permuted blocks between the front and back ends.
// Depends on btc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btc_queue import btc_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire block_type push_block,
   output logic           full,
   output logic           empty,
   input  wire logic      pop,
   output block_type      head
);

   block_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_block;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/btc_back.sv =====
// Back end: sends the head block of the queue out one byte per item.
// Depends on btc_pkg; drains btc_queue.
`timescale 1ns / 1ps
`default_nettype none

module btc_back import btc_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_empty,
   input  wire block_type head,
   output logic           pop,
   output logic           out_valid,
   input  wire logic      out_ready,
   output data_byte_type  out_byte,
   output logic           out_last
);

   logic             valid_ff, valid_in;
   data_byte_type    byte_ff;
   logic             last_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             load;
   logic             at_last;

   assign load    = !q_empty && (!valid_ff || out_ready);
   assign at_last = (idx_ff == head.last_idx);
   assign pop     = load && at_last;

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_last ? '0 : idx_ff + 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head.bytes[idx_ff];
         last_ff <= at_last;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/block_transposition_cipher.sv =====
// Block transposition cipher: byte stream in, permuted blocks out.
// One byte per cycle in and out while the queue has room and rsp_tready is high; input stalls
// only while two finished blocks wait for the output.
// The edge that takes the last input byte of a block writes the block to the queue; the output
// register loads its first byte once that block is at the head and the register is free.
// Reset is synchronous and active high; it restores the register defaults and empties the block.
`timescale 1ns / 1ps
`default_nettype none

module block_transposition_cipher import btc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input stream.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [BYTE_W-1:0]     req_tdata,   // [7:0] data_byte
   // Result stream.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [BYTE_W-1:0]          rsp_tdata,   // [7:0] out_byte
   output logic                       rsp_tlast,   // block_end
   // Register port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // Register file. Registers sit at word addresses, so the register index
   // is the word part of the address; the two byte-offset bits are ignored.
   logic [LEN_W-1:0] len_ff;
   logic [TAB_W-1:0] tab_ff;
   logic             dir_ff;
   logic             wr_en;
   csr_index_type    csr_idx;
   cfg_type          cfg;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= BLOCK_LEN_RESET;
         tab_ff <= PERM_TABLE_RESET;
         dir_ff <= DIRECTION_RESET;
      end else if (wr_en) begin
         unique case (csr_idx)
            CSR_BLOCK_LEN:  len_ff <= csr_pwdata[LEN_W-1:0];
            CSR_PERM_TABLE: tab_ff <= csr_pwdata[TAB_W-1:0];
            CSR_DIRECTION:  dir_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_BLOCK_LEN:  csr_prdata = CSR_DATA_W'(len_ff);
         CSR_PERM_TABLE: csr_prdata = CSR_DATA_W'(tab_ff);
         CSR_DIRECTION:  csr_prdata = CSR_DATA_W'(dir_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Writing the length drops any partly collected block in the front end.
   assign cfg.last_idx   = eff_last(len_ff);
   assign cfg.table_bits = tab_ff;
   assign cfg.decrypt    = dir_ff;
   assign cfg.len_write  = wr_en && (csr_idx == CSR_BLOCK_LEN);

   logic      q_full;
   logic      q_empty;
   logic      push_valid;
   logic      pop;
   block_type push_block;
   block_type head;

   // The front end takes a byte every cycle while the queue has room; a full
   // block is permuted as its last byte arrives and pushed whole.
   btc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_block (push_block)
   );

   // Two blocks of slack let one block fill while the previous one drains.
   btc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_block (push_block),
      .full       (q_full),
      .empty      (q_empty),
      .pop        (pop),
      .head       (head)
   );

   // The back end walks the head block through an output register.
   btc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/btc_checker.sv =====
// Port-level checks for the block transposition cipher, bound to the top level.
// Depends on btc_pkg and block_transposition_cipher.
`timescale 1ns / 1ps
`default_nettype none

module btc_checker import btc_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [BYTE_W-1:0]     rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [CSR_DATA_W-1:0] csr_prdata,
   input wire logic                  csr_pready
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

   a_dir_read: assert property (@(posedge clock) disable iff (reset)
      csr_paddr[CSR_ADDR_W-1:2] == CSR_DIRECTION |-> csr_prdata[CSR_DATA_W-1:1] == '0)
      else $error("direction readback wider than one bit");

endmodule

bind block_transposition_cipher btc_checker u_btc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_paddr  (csr_paddr),
   .csr_prdata (csr_prdata),
   .csr_pready (csr_pready)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for block_transposition_cipher: directed tests, then random streams.
// Depends on btc_pkg and the block_transposition_cipher RTL; needs no other files.
`timescale 1ns / 1ps

module tb_top import btc_pkg::*; ();

   localparam int CLOCK_HALF      = 6;
   localparam int RESET_CYCLES    = 8;
   // Extra cycles waited once no byte is owed, to cover a block that is still being filled or drained.
   localparam int DRAIN_CYCLES    = 6;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 150;
   // Register index that the block does not implement; writes must be dropped.
   localparam int UNUSED_REG_INDEX = 3;
   localparam int CSR_STRIDE       = 4;

   // One byte of a finished block as it should leave the result stream.
   typedef struct packed {
      data_byte_type out_byte;
      logic          block_end;
   } cipher_byte_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   block_transposition_cipher dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Shadow copy of the registers and of the block being collected. The
   // buffer is only ever read at slots written earlier in the same block.
   logic [LEN_W-1:0]  shadow_len     = BLOCK_LEN_RESET;
   logic [TAB_W-1:0]  shadow_table   = PERM_TABLE_RESET;
   logic              shadow_decrypt = DIRECTION_RESET;
   data_byte_type     block_bytes [MAX_BLOCK];
   int                fill_level     = 0;

   // Permuted bytes still owed by the block, oldest first.
   cipher_byte_type   pending_cipher_bytes [$];

   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Block length as the hardware uses it: zero counts as one, and anything
   // above the table size is clipped to it.
   function automatic int active_len();
      int n;
      n = int'(shadow_len);
      if (n < 1) n = 1;
      if (n > LEN_CAP) n = LEN_CAP;
      return n;
   endfunction

   // Takes one accepted byte into the shadow block. When the block is full it
   // computes the permuted block and queues it. Encrypt scatters byte i to
   // slot table[i], so a table with repeated entries lets the later byte win
   // and leaves unclaimed slots at zero. Decrypt gathers slot i from
   // byte table[i]. In both directions an entry past the block end has no
   // effect, except that decrypt then yields a zero byte.
   function automatic void absorb_byte(input data_byte_type d);
      int               n;
      int               i;
      logic [ENT_W-1:0] t;
      data_byte_type    res [MAX_BLOCK];
      n = active_len();
      if (fill_level >= n) fill_level = 0;
      block_bytes[fill_level] = d;
      fill_level++;
      if (fill_level < n) return;
      fill_level = 0;
      for (i = 0; i < MAX_BLOCK; i++) res[i] = '0;
      for (i = 0; i < n; i++) begin
         t = shadow_table[ENT_W*i +: ENT_W];
         if (!shadow_decrypt) begin
            if (int'(t) < n) res[t] = block_bytes[i];
         end else begin
            res[i] = (int'(t) < n) ? block_bytes[t] : '0;
         end
      end
      for (i = 0; i < n; i++) begin
         pending_cipher_bytes.push_back('{out_byte: res[i], block_end: (i == n - 1)});
      end
   endfunction

   // Value a register should read back with, from the shadow copy.
   function automatic logic [CSR_DATA_W-1:0] shadow_reg(input int index);
      logic [CSR_DATA_W-1:0] v;
      case (index)
         CSR_BLOCK_LEN:  v = CSR_DATA_W'(shadow_len);
         CSR_PERM_TABLE: v = CSR_DATA_W'(shadow_table);
         default:        v = CSR_DATA_W'(shadow_decrypt);
      endcase
      return v;
   endfunction

   // APB read: setup, then access; the data is taken at the access edge.
   task automatic check_register(input int index);
      logic [CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(index * CSR_STRIDE);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== shadow_reg(index)) begin
         $error("register %0d readback: expected %0h actual %0h", index,
                shadow_reg(index), got);
         error_count++;
      end
   endtask

   // APB write. The register changes at the access edge, which is also where
   // the shadow copy is updated. Writing the length drops a partial block.
   // Known registers are read back right after.
   task automatic write_register(input int index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index * CSR_STRIDE);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (index)
         CSR_BLOCK_LEN: begin
            shadow_len = value[LEN_W-1:0];
            fill_level = 0;
         end
         CSR_PERM_TABLE: shadow_table = value[TAB_W-1:0];
         CSR_DIRECTION:  shadow_decrypt = value[0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (index < UNUSED_REG_INDEX) check_register(index);
   endtask

   // Offers one item on the input stream, after a random number of idle
   // cycles, and holds it until the block takes it. The task returns in the
   // time step of the accepting edge, before anything else is driven there,
   // so the next call can keep tvalid high without a second assignment.
   task automatic send_byte(input data_byte_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      absorb_byte(d);
   endtask

   // Stops sending and waits until every owed byte has come out, plus a few
   // cycles for a block that produces nothing yet. Registers are only
   // written after this.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_cipher_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A random table whose first n entries are a permutation of 0..n-1; the
   // entries past the block end are arbitrary and must not matter.
   function automatic logic [TAB_W-1:0] random_permutation(input int n);
      int               slot [TAB_ENTRIES];
      int               i;
      int               j;
      int               tmp;
      logic [TAB_W-1:0] packed_table;
      for (i = 0; i < TAB_ENTRIES; i++) slot[i] = i;
      for (i = n - 1; i > 0; i--) begin
         j       = $urandom_range(i, 0);
         tmp     = slot[i];
         slot[i] = slot[j];
         slot[j] = tmp;
      end
      for (i = n; i < TAB_ENTRIES; i++) slot[i] = $urandom_range(TAB_ENTRIES - 1, 0);
      for (i = 0; i < TAB_ENTRIES; i++) packed_table[ENT_W*i +: ENT_W] = ENT_W'(slot[i]);
      return packed_table;
   endfunction

   // Registers hold their reset values; one block with the default table,
   // carrying the byte extremes.
   task automatic test_reset_state();
      check_register(CSR_BLOCK_LEN);
      check_register(CSR_PERM_TABLE);
      check_register(CSR_DIRECTION);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_byte(8'hA5);
      send_byte(8'h01);
      send_byte(8'h80);
      wait_drained();
   endtask

   // A length of one turns every item into a one-byte block of its own.
   task automatic test_length_one();
      write_register(CSR_BLOCK_LEN, 1);
      send_byte(8'hFF);
      send_byte(8'h00);
      wait_drained();
   endtask

   // A length of zero behaves as a length of one.
   task automatic test_length_zero();
      write_register(CSR_BLOCK_LEN, 0);
      send_byte(8'h7E);
      wait_drained();
   endtask

   // The largest length code is clipped to a full eight-byte block; the
   // reversing table is run in decrypt direction with walking ones.
   task automatic test_length_over();
      int i;
      write_register(CSR_BLOCK_LEN, 15);
      write_register(CSR_PERM_TABLE, 24'o01234567);
      write_register(CSR_DIRECTION, 1);
      for (i = 0; i < MAX_BLOCK; i++) send_byte(data_byte_type'(1 << i));
      wait_drained();
   endtask

   // Tables that are not permutations: all entries zero in encrypt direction
   // (later bytes overwrite, other slots stay zero), then all entries past
   // the block end in decrypt direction (every byte comes out zero).
   task automatic test_broken_tables();
      write_register(CSR_BLOCK_LEN, 3);
      write_register(CSR_PERM_TABLE, 24'h000000);
      write_register(CSR_DIRECTION, 0);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      wait_drained();
      write_register(CSR_PERM_TABLE, 24'hFFFFFF);
      write_register(CSR_DIRECTION, 1);
      send_byte(8'h44);
      send_byte(8'h55);
      send_byte(8'h66);
      wait_drained();
   endtask

   // Rewriting the length while a block is half full throws that half away.
   task automatic test_length_rewrite();
      write_register(CSR_PERM_TABLE, 24'o76543210);
      write_register(CSR_DIRECTION, 0);
      write_register(CSR_BLOCK_LEN, 4);
      send_byte(8'hDE);
      send_byte(8'hAD);
      wait_drained();
      write_register(CSR_BLOCK_LEN, 2);
      send_byte(8'hBE);
      send_byte(8'hEF);
      wait_drained();
   endtask

   // A write to an index the block lacks must change nothing; the next block
   // still follows the earlier settings.
   task automatic test_unknown_register();
      write_register(UNUSED_REG_INDEX, 32'hFFFF_FFFF);
      send_byte(8'hC3);
      send_byte(8'h3C);
      wait_drained();
   endtask

   // Random stream: each segment drains the block, picks new settings and
   // sends a few whole blocks of random bytes, sometimes followed by a stray
   // partial block. The length is sometimes left alone so that a partial
   // block carries over into the next segment.
   task automatic run_random_phase(input int item_goal, input int send_pct,
                                   input int recv_pct);
      int               sent;
      int               len_code;
      int               n;
      int               blocks;
      int               extra;
      int               k;
      logic [TAB_W-1:0] tab;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < item_goal) begin
         wait_drained();
         if ($urandom_range(99) < 85) begin
            len_code = $urandom_range(LEN_CAP, 1);
         end else begin
            len_code = $urandom_range(1) ? 0 : $urandom_range(15, LEN_CAP + 1);
         end
         if ($urandom_range(99) < 75) write_register(CSR_BLOCK_LEN, len_code);
         n = active_len();
         if ($urandom_range(99) < 80) begin
            tab = random_permutation(n);
         end else begin
            tab = TAB_W'($urandom);
         end
         write_register(CSR_PERM_TABLE, CSR_DATA_W'(tab));
         write_register(CSR_DIRECTION, $urandom);
         if ($urandom_range(99) < 5) write_register(UNUSED_REG_INDEX, $urandom);
         blocks = $urandom_range(4, 1);
         for (k = 0; k < blocks * n; k++) begin
            send_byte(data_byte_type'($urandom));
            sent++;
         end
         if ($urandom_range(99) < 20) begin
            extra = $urandom_range(n - 1, 0);
            for (k = 0; k < extra; k++) begin
               send_byte(data_byte_type'($urandom));
               sent++;
            end
         end
      end
   endtask

   // The receiver stalls at random with the current percentage.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Every result item taken is compared with the oldest owed byte.
   always @(posedge clock) begin : check_results
      cipher_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cipher_bytes.size() == 0) begin
            $error("unexpected result item: out_byte %0h block_end %0b", rsp_tdata,
                   rsp_tlast);
            error_count++;
         end else begin
            want = pending_cipher_bytes.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               $error("out_byte mismatch: expected %0h actual %0h", want.out_byte,
                      rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.block_end) begin
               $error("block_end mismatch: expected %0b actual %0b", want.block_end,
                      rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("block_transposition_cipher verification failed");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 29;
      recv_idle_pct = 57;
      test_reset_state();
      test_length_one();
      test_length_zero();
      test_length_over();
      test_broken_tables();
      test_length_rewrite();
      test_unknown_register();

      // Slow sender with a slower receiver, then the reverse, then both at
      // full rate so that blocks fill and drain back to back.
      run_random_phase(ITEMS_PER_PHASE, 29, 57);
      run_random_phase(ITEMS_PER_PHASE, 57, 29);
      run_random_phase(ITEMS_PER_PHASE, 0, 0);

      wait_drained();
      if (error_count == 0) begin
         $display("block_transposition_cipher verification clean");
      end else begin
         $display("block_transposition_cipher verification failed");
      end
      $finish;
   end

endmodule
